@@ rtl/core/ase_pkg.sv @@
// ----------------------------------------------------------------------------
// ase_pkg
// Shared widths, constants and state encoding of the arctanh series evaluator.
// ----------------------------------------------------------------------------
package ase_pkg;

   // argument and term magnitudes are unsigned Q1.30 (value up to 1.0)
   localparam int MAG_W     = 31;
   localparam int FRAC_BITS = 30;
   localparam int ARG_W     = 31;
   localparam int TOL_W     = 31;
   localparam int RES_W     = 32;
   localparam int TERMS_W   = 11;

   // series term cap and the widths that follow from it
   localparam int MAX_TERMS = 1024;
   localparam int CNT_W     = $clog2(MAX_TERMS + 1);
   localparam int DIVR_W    = $clog2(2 * MAX_TERMS);
   localparam int SUM_W     = MAG_W + $clog2(MAX_TERMS) + 1;

   // divider steps one quotient bit per cycle
   localparam int DIV_CNT_W = $clog2(MAG_W);

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(1024);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_DIVIDE,
      ST_POWER,
      ST_FINISH
   } state_type;

endpackage

@@ rtl/core/ase_mul.sv @@
// ----------------------------------------------------------------------------
// ase_mul
// Shared Q1.30 multiplier: registered product, truncated back to Q1.30.
// ----------------------------------------------------------------------------
module ase_mul (
   input  logic                       clock,
   input  logic                       mul_en,
   input  logic [ase_pkg::MAG_W-1:0]  mul_a,
   input  logic [ase_pkg::MAG_W-1:0]  mul_b,
   output logic [ase_pkg::MAG_W-1:0]  mul_p
);
   import ase_pkg::*;

   logic [2*MAG_W-1:0] prod;
   logic [MAG_W-1:0]   p_ff;
   logic [MAG_W-1:0]   p_in;

   // drop the low fraction bits; operands never exceed 1.0 so the rest fits
   always_comb begin
      prod = (2*MAG_W)'(mul_a) * (2*MAG_W)'(mul_b);
      p_in = prod[FRAC_BITS +: MAG_W];
   end

   // hold the product until the next multiply
   always_ff @(posedge clock) begin
      if (mul_en) begin
         p_ff <= p_in;
      end
   end

   assign mul_p = p_ff;

endmodule

@@ rtl/core/ase_div.sv @@
// ----------------------------------------------------------------------------
// ase_div
// Restoring divider, one quotient bit per cycle, quotient truncated to zero.
// ----------------------------------------------------------------------------
module ase_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       div_start,
   input  logic [ase_pkg::MAG_W-1:0]  div_dividend,
   input  logic [ase_pkg::DIVR_W-1:0] div_divisor,
   output logic                       div_done,
   output logic [ase_pkg::MAG_W-1:0]  div_quotient
);
   import ase_pkg::*;

   localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(MAG_W - 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIVR_W-1:0]    rem_ff, rem_in;
   logic [MAG_W-1:0]     quo_ff, quo_in;
   logic [DIVR_W-1:0]    dvsr_ff, dvsr_in;
   logic [DIVR_W:0]      trial;
   logic [DIVR_W:0]      diff;
   logic                 qbit;

   // shift in the next dividend bit, subtract when the divisor fits
   always_comb begin
      trial   = {rem_ff, quo_ff[MAG_W-1]};
      diff    = trial - {1'b0, dvsr_ff};
      qbit    = (trial >= {1'b0, dvsr_ff});
      busy_in = busy_ff;
      done_in = busy_ff && (cnt_ff == LAST_STEP);
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvsr_in = dvsr_ff;
      if (div_start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = div_dividend;
         dvsr_in = div_divisor;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         rem_in = qbit ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
         quo_in = {quo_ff[MAG_W-2:0], qbit};
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvsr_ff <= dvsr_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = quo_ff;

endmodule

@@ rtl/core/arctanh_series_evaluator.sv @@
// Per request the block squares x, then for each series term divides the
// power by 2n+1 in the 31-step divider and, unless done, multiplies it by x^2.
// A new request is stalled until the sequencer is back in idle. A new
// request is taken while the previous response still waits.
// Reset (synchronous) returns to idle, drops the response and sets the
// tolerance to 1024.
// ----------------------------------------------------------------------------
// arctanh_series_evaluator
// Sums the Maclaurin series of arctanh(x) with a shared multiplier and divider.
// ----------------------------------------------------------------------------
module arctanh_series_evaluator (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [ase_pkg::ARG_W-1:0]  req_arg_x,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ase_pkg::RES_W-1:0]  rsp_result,
   output logic [ase_pkg::TERMS_W-1:0]       rsp_terms_used,
   output logic                              rsp_hit_limit,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ase_pkg::TOL_W-1:0]         csr_tolerance
);
   import ase_pkg::*;

   state_type            state_ff, state_in;
   logic [TOL_W-1:0]     tol_ff, tol_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]     result_ff, result_in;
   logic [TERMS_W-1:0]   terms_ff, terms_in;
   logic                 limit_ff, limit_in;
   logic [MAG_W-1:0]     pw_ff, pw_in;
   logic [MAG_W-1:0]     sq_ff, sq_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [CNT_W-1:0]     n_ff, n_in;
   logic                 neg_ff, neg_in;
   logic                 capped_ff, capped_in;

   logic                 mul_en;
   logic [MAG_W-1:0]     mul_a, mul_b, mul_p;
   logic                 div_start;
   logic [MAG_W-1:0]     div_dividend;
   logic [DIVR_W-1:0]    div_divisor;
   logic                 div_done;
   logic [MAG_W-1:0]     div_quotient;

   logic [MAG_W-1:0]     arg_raw;
   logic [MAG_W-1:0]     arg_mag;
   logic [CNT_W-1:0]     n_next;
   logic [63:0]          rmag;
   logic [RES_W-1:0]     mag_sat;
   logic                 rsp_free;

   ase_mul u_mul (
      .clock (clock),
      .mul_en(mul_en),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   ase_div u_div (
      .clock       (clock),
      .reset       (reset),
      .div_start   (div_start),
      .div_dividend(div_dividend),
      .div_divisor (div_divisor),
      .div_done    (div_done),
      .div_quotient(div_quotient)
   );

   // sequence the terms through the shared multiplier and divider
   always_comb begin
      arg_raw  = MAG_W'(req_arg_x);
      arg_mag  = arg_raw[MAG_W-1] ? (MAG_W'(0) - arg_raw) : arg_raw;
      n_next   = n_ff + 1'b1;
      rmag     = 64'(sum_ff >> 3);
      rsp_free = !rsp_valid_ff || !rsp_stall;

      // saturate the Q5.27 magnitude, then apply the sign of x
      if (neg_ff) begin
         mag_sat = (rmag > 64'h8000_0000) ? 32'h8000_0000 : rmag[RES_W-1:0];
      end else begin
         mag_sat = (rmag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rmag[RES_W-1:0];
      end

      state_in     = state_ff;
      tol_in       = tol_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      result_in    = result_ff;
      terms_in     = terms_ff;
      limit_in     = limit_ff;
      pw_in        = pw_ff;
      sq_in        = sq_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      neg_in       = neg_ff;
      capped_in    = capped_ff;
      mul_en       = 1'b0;
      mul_a        = pw_ff;
      mul_b        = sq_ff;
      div_start    = 1'b0;
      div_dividend = pw_ff;
      div_divisor  = DIVR_W'({n_ff, 1'b1});
      req_stall    = (state_ff != ST_IDLE);

      if (csr_valid) begin
         tol_in = csr_tolerance;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               neg_in   = arg_raw[MAG_W-1];
               pw_in    = arg_mag;
               sum_in   = '0;
               n_in     = '0;
               mul_en   = 1'b1;
               mul_a    = arg_mag;
               mul_b    = arg_mag;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            sq_in     = mul_p;
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               sum_in = sum_ff + SUM_W'(div_quotient);
               n_in   = n_next;
               if (div_quotient < tol_ff) begin
                  capped_in = 1'b0;
                  state_in  = ST_FINISH;
               end else if (n_next >= CNT_W'(MAX_TERMS)) begin
                  capped_in = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  mul_en   = 1'b1;
                  state_in = ST_POWER;
               end
            end
         end
         ST_POWER: begin
            pw_in        = mul_p;
            div_start    = 1'b1;
            div_dividend = mul_p;
            state_in     = ST_DIVIDE;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               result_in    = RES_W'(0) - mag_sat;
               if (!neg_ff) begin
                  result_in = mag_sat;
               end
               terms_in     = TERMS_W'(n_ff);
               limit_in     = capped_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      result_ff <= result_in;
      terms_ff  <= terms_in;
      limit_ff  <= limit_in;
      pw_ff     <= pw_in;
      sq_ff     <= sq_in;
      sum_ff    <= sum_in;
      neg_ff    <= neg_in;
      capped_ff <= capped_in;
   end

   assign csr_ready      = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result     = result_ff;
   assign rsp_terms_used = terms_ff;
   assign rsp_hit_limit  = limit_ff;

`ifndef ASSERT_OFF
   // the divider only finishes while the sequencer waits on it
   a_div_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider done outside of divide state");

   // the term count never passes the cap
   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      n_ff <= CNT_W'(MAX_TERMS))
      else $error("term count beyond cap");

   // a capped response always reports the full term count
   a_limit_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_limit |-> rsp_terms_used == TERMS_W'(MAX_TERMS))
      else $error("hit_limit with short term count");

   // a new response is only loaded once the previous one has left
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("pending response overwritten");
`endif

endmodule
